@@ rtl/adps_pkg.sv @@
// Shared types and constants for the anti-aliased disc pixel shader.
// Holds the item structs, the register indexes and the pipeline sizing.
// No dependencies.
`default_nettype none

package adps_pkg;

	localparam int PANEL_WIDTH  = 64;
	localparam int PANEL_HEIGHT = 64;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BG_BLUE  = 2'd2;

	localparam int SQ_W                = 30;
	localparam int ROOT_W              = SQ_W / 2;
	localparam int SQRT_BITS_PER_STAGE = 3;
	localparam int SQRT_STAGES         = ROOT_W / SQRT_BITS_PER_STAGE;

	typedef struct packed {
		logic [5:0] pixel_x;
		logic [5:0] pixel_y;
		logic [9:0] center_x;
		logic [9:0] center_y;
		logic [7:0] disc_radius;
		logic [7:0] fill_red;
		logic [7:0] fill_green;
		logic [7:0] fill_blue;
	} pixel_in_t;

	typedef struct packed {
		logic       written;
		logic [7:0] alpha;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pixel_out_t;

	typedef struct packed {
		logic [7:0] disc_radius;
		logic [7:0] fill_red;
		logic [7:0] fill_green;
		logic [7:0] fill_blue;
		logic       clip;
	} side_t;

endpackage

`default_nettype wire

@@ rtl/antialiased_disc_pixel_shader_unit.sv @@
// Top level of the anti-aliased disc pixel shader.
// Depends on adps_pkg, adps_isqrt and adps_blend.
// The unit accepts one pixel item per cycle while in_stall is low. Its
// pipeline holds the delta, square and sum stages, the distance square
// root, whose fifteen root bits are resolved three per stage over five
// stages, and the coverage, alpha and two blend stages. The whole
// pipeline holds while a result waits at the output, so no item is lost.
`default_nettype none

module antialiased_disc_pixel_shader_unit import adps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pixel_in_t            in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pixel_out_t           out_item
);

	logic [7:0] bg_red_q;
	logic [7:0] bg_green_q;
	logic [7:0] bg_blue_q;

	logic advance;

	logic               valid_s1, valid_s2, valid_s3;
	logic               valid_s9, valid_s10, valid_s11, valid_s12;
	logic signed [10:0] dx_s1, dy_s1;
	side_t              side_s1, side_s2, side_s3, side_s9;
	logic [19:0]        sqx_s2, sqy_s2;
	logic [SQ_W-1:0]    op_s3;

	logic              valid_s8;
	logic [ROOT_W-1:0] dist_s8;
	side_t             side_s8;

	logic [8:0] cov_s9;
	logic [7:0] alpha_s10, alpha_s11, alpha_s12;
	logic       written_s10, written_s11, written_s12;
	logic [7:0] fill_red_s10, fill_green_s10, fill_blue_s10;
	logic [7:0] red_s12, green_s12, blue_s12;

	logic signed [10:0] dx_in, dy_in;
	logic               clip_in;
	logic signed [21:0] dx_sq, dy_sq;
	logic [20:0]        sq_sum;
	logic signed [16:0] cov_raw;
	logic [8:0]         cov_clamped;
	logic [16:0]        alpha_full;

	assign advance  = !(valid_s12 && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_red_q   <= '0;
			bg_green_q <= '0;
			bg_blue_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BG_RED:   bg_red_q   <= cfg_data;
				REG_BG_GREEN: bg_green_q <= cfg_data;
				REG_BG_BLUE:  bg_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx_in = $signed({1'b0, in_item.pixel_x, 4'b1000}) - $signed({1'b0, in_item.center_x});
	assign dy_in = $signed({1'b0, in_item.pixel_y, 4'b1000}) - $signed({1'b0, in_item.center_y});
	assign clip_in = (int'(in_item.pixel_x) >= PANEL_WIDTH) ||
		(int'(in_item.pixel_y) >= PANEL_HEIGHT);

	assign dx_sq  = dx_s1 * dx_s1;
	assign dy_sq  = dy_s1 * dy_s1;
	assign sq_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else if (advance) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s1   <= dx_in;
			dy_s1   <= dy_in;
			side_s1 <= '{disc_radius: in_item.disc_radius, fill_red: in_item.fill_red,
				fill_green: in_item.fill_green, fill_blue: in_item.fill_blue, clip: clip_in};
			sqx_s2  <= dx_sq[19:0];
			sqy_s2  <= dy_sq[19:0];
			side_s2 <= side_s1;
			op_s3   <= {1'b0, sq_sum, 8'b0};
			side_s3 <= side_s2;
		end
	end

	adps_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s3),
		.in_op     (op_s3),
		.in_side   (side_s3),
		.out_valid (valid_s8),
		.out_root  (dist_s8),
		.out_side  (side_s8)
	);

	assign cov_raw = $signed({5'b0, side_s8.disc_radius, 4'b0}) + 17'sd128
		- $signed({2'b0, dist_s8});

	always_comb begin
		if (side_s8.clip || cov_raw <= 17'sd0) begin
			cov_clamped = '0;
		end else if (cov_raw > 17'sd256) begin
			cov_clamped = 9'd256;
		end else begin
			cov_clamped = cov_raw[8:0];
		end
	end

	assign alpha_full = {cov_s9, 8'b0} - {8'b0, cov_s9} + 17'd128;

	always_ff @(posedge clk) begin
		if (advance) begin
			cov_s9         <= cov_clamped;
			side_s9        <= side_s8;
			alpha_s10      <= alpha_full[15:8];
			written_s10    <= (cov_s9 != 9'd0);
			fill_red_s10   <= side_s9.fill_red;
			fill_green_s10 <= side_s9.fill_green;
			fill_blue_s10  <= side_s9.fill_blue;
			alpha_s11      <= alpha_s10;
			written_s11    <= written_s10;
			alpha_s12      <= alpha_s11;
			written_s12    <= written_s11;
		end
	end

	adps_blend u_blend_red (
		.clk (clk),
		.en  (advance),
		.fg  (fill_red_s10),
		.bg  (bg_red_q),
		.a   (alpha_s10),
		.c   (red_s12)
	);

	adps_blend u_blend_green (
		.clk (clk),
		.en  (advance),
		.fg  (fill_green_s10),
		.bg  (bg_green_q),
		.a   (alpha_s10),
		.c   (green_s12)
	);

	adps_blend u_blend_blue (
		.clk (clk),
		.en  (advance),
		.fg  (fill_blue_s10),
		.bg  (bg_blue_q),
		.a   (alpha_s10),
		.c   (blue_s12)
	);

	assign out_valid = valid_s12;
	assign out_item  = '{written: written_s12, alpha: alpha_s12, out_red: red_s12,
		out_green: green_s12, out_blue: blue_s12};

endmodule

`default_nettype wire

@@ rtl/adps_isqrt.sv @@
// Pipelined integer square root with a sideband that travels with each item.
// Resolves a fixed number of root bits per stage; depends on adps_pkg.
`default_nettype none

module adps_isqrt import adps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   in_op,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output side_t             out_side
);

	localparam int REM_W = ROOT_W + 2;
	localparam int TRY_W = REM_W + 2;

	typedef struct packed {
		logic [SQ_W-1:0]   op;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
		logic [TRY_W-1:0] trial;
		logic [TRY_W-1:0] sub;
		sqrt_state_t      r;
		trial = {s.rem, s.op[SQ_W-1 -: 2]};
		sub   = {2'b00, s.root, 2'b01};
		r.op  = {s.op[SQ_W-3:0], 2'b00};
		if (trial >= sub) begin
			r.rem  = REM_W'(trial - sub);
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = trial[REM_W-1:0];
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	sqrt_state_t st_s    [SQRT_STAGES];
	side_t       side_s  [SQRT_STAGES];
	logic        valid_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		sqrt_state_t cur;
		sqrt_state_t nxt;
		side_t       side_cur;
		logic        valid_cur;

		if (k == 0) begin : g_first
			assign cur       = '{op: in_op, rem: '0, root: '0};
			assign side_cur  = in_side;
			assign valid_cur = in_valid;
		end else begin : g_next
			assign cur       = st_s[k-1];
			assign side_cur  = side_s[k-1];
			assign valid_cur = valid_s[k-1];
		end

		always_comb begin
			nxt = cur;
			for (int i = 0; i < SQRT_BITS_PER_STAGE; i++) begin
				nxt = sqrt_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]   <= nxt;
				side_s[k] <= side_cur;
			end
		end
	end

	assign out_valid = valid_s[SQRT_STAGES-1];
	assign out_root  = st_s[SQRT_STAGES-1].root;
	assign out_side  = side_s[SQRT_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/adps_blend.sv @@
// Two-stage blend of one color channel: weighted sum, then divide by 255.
// Depends on no package items.
`default_nettype none

module adps_blend (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] fg,
	input  logic [7:0] bg,
	input  logic [7:0] a,
	output logic [7:0] c
);

	logic [15:0] fg_prod;
	logic [15:0] bg_prod;
	logic [15:0] sum_s1;
	logic [16:0] quo;

	assign fg_prod = {8'b0, fg} * {8'b0, a};
	assign bg_prod = {8'b0, bg} * {8'b0, 8'd255 - a};

	// The sum stays at or below 65025, where (n + n/256 + 1) / 256 equals n / 255.
	assign quo = {1'b0, sum_s1} + {9'b0, sum_s1[15:8]} + 17'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= fg_prod + bg_prod;
			c      <= quo[15:8];
		end
	end

endmodule

`default_nettype wire
